FILE: rtl/acbm_pkg.sv
// Shared types, constants and cost helpers for the alignment cost block.
// No dependencies; imported by the cell, the top level and the checker.
`timescale 1ns / 1ps

package acbm_pkg;

   localparam int MAX_QUERY_LEN = 128;
   localparam int COST_W        = 16;
   localparam int LEN_W         = $clog2(MAX_QUERY_LEN + 1);
   localparam int IDX_W         = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
   localparam int ENTRY_W       = 10;
   localparam int CFG_W         = 4;

   localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};
   localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};

   // csr register indexes
   localparam logic REG_GAP_COST      = 1'b0;
   localparam logic REG_MISMATCH_COST = 1'b1;

   // request op codes
   localparam logic OP_QUERY    = 1'b0;
   localparam logic OP_DATABASE = 1'b1;

   typedef logic [COST_W-1:0] cost_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [CFG_W-1:0]  cfg_type;

   typedef struct packed {
      logic       op;
      logic [7:0] symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [15:0]        entry_cost;
      logic [ENTRY_W-1:0] entry_index;
      logic [15:0]        min_cost;
      logic [ENTRY_W-1:0] best_index;
      logic               query_overflow;
   } rsp_type;

   // word moving down the cell chain, one database symbol of the wavefront
   typedef struct packed {
      logic       first;     // first symbol of an entry: row starts from init
      logic       last;
      logic [7:0] symbol;
      cost_type   left_old;  // previous row value of the left neighbor
      cost_type   left_new;  // updated row value of the left neighbor
      len_type    remain;    // cells left until the query end
      cost_type   result;    // row value at the query end, once reached
   } token_type;

   function automatic cost_type sat_add(cost_type a, cfg_type b);
      logic [COST_W:0] s;
      s = {1'b0, a} + (COST_W + 1)'(b);
      return s[COST_W] ? COST_MAX : s[COST_W-1:0];
   endfunction

   function automatic cost_type min2(cost_type a, cost_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [15:0] clamp16(cost_type v);
      if (COST_W > 16 && v > cost_type'(17'h0FFFF)) begin
         return 16'hFFFF;
      end
      return 16'(v);
   endfunction

endpackage

FILE: rtl/alignment_cost_best_match.sv
// Top level of the best-match alignment cost block: query loading, row start,
// result bookkeeping and the chain of acbm_cell. Depends on acbm_pkg.
`timescale 1ns / 1ps

// Usage:
// Request words (req_valid/req_ready, req_data) carry op, symbol and last.
// op = query loads query symbols into the cell row, one per cell; symbols
// past the row capacity are dropped and set query_overflow. op = database
// streams the symbols of database entries; the word with last set finishes
// an entry and gives one response word (rsp_valid/rsp_ready, rsp_data) with
// the entry cost, its index and the best cost and index since the query load.
// Database symbols are taken one per cycle while the row is not held and travel
// down the cell row as a wavefront, one cell per cycle. A response is registered
// after its last symbol passes the input register and every cell of the row.
// A query symbol waits until no database word is left in the input register
// or the row. When a response waits and a second finished entry reaches the
// row end, the whole row and the input hold until the receiver takes the
// response. Reset (synchronous) empties the row and the query, sets gap_cost
// to 2 and mismatch_cost to 3. csr writes are taken at once; the user must
// write them only while the block is idle, which the block does not enforce.

module alignment_cost_best_match
   import acbm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_index,
   input  cfg_type csr_wdata
);

   cfg_type            gap_ff;
   cfg_type            mis_ff;
   logic               query_open_ff;
   len_type            qlen_ff;
   logic               overflow_ff;
   logic               row_started_ff;
   cost_type           row0_ff;
   logic [ENTRY_W-1:0] entry_ff;
   cost_type           best_ff;
   logic [ENTRY_W-1:0] best_idx_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               tok0_valid_ff;
   token_type          tok0_ff;

   logic                   stage_valid [0:MAX_QUERY_LEN];
   token_type              stage_tok   [0:MAX_QUERY_LEN];
   logic [MAX_QUERY_LEN:0] busy_vec;
   logic [MAX_QUERY_LEN-1:0] q_we;

   logic      enable;
   logic      busy;
   logic      accept;
   logic      load;
   logic      db;
   logic      complete;
   len_type   base_len;
   cost_type  row0_old;
   cost_type  row0_new;
   token_type tok0_in;
   logic      take_best;
   cost_type  best_in;
   logic [ENTRY_W-1:0] best_idx_in;

   assign stage_valid[0] = tok0_valid_ff;
   assign stage_tok[0]   = tok0_ff;

   always_comb begin
      for (int k = 0; k <= MAX_QUERY_LEN; k++) begin
         busy_vec[k] = stage_valid[k];
      end
   end

   assign busy     = |busy_vec;
   assign enable   = !(stage_valid[MAX_QUERY_LEN] && stage_tok[MAX_QUERY_LEN].last &&
                       rsp_valid_ff && !rsp_ready);
   assign req_ready = enable && !(req_data.op == OP_QUERY && busy);
   assign accept   = req_valid && req_ready;
   assign load     = accept && (req_data.op == OP_QUERY);
   assign db       = accept && (req_data.op == OP_DATABASE);
   assign complete = enable && stage_valid[MAX_QUERY_LEN] && stage_tok[MAX_QUERY_LEN].last;
   assign base_len = query_open_ff ? qlen_ff : '0;

   generate
      for (genvar k = 0; k < MAX_QUERY_LEN; k++) begin : g_we
         assign q_we[k] = load && (base_len < len_type'(MAX_QUERY_LEN)) &&
                          (base_len[IDX_W-1:0] == IDX_W'(k));
      end
   endgenerate

   always_comb begin
      row0_old         = row_started_ff ? row0_ff : '0;
      row0_new         = sat_add(row0_old, gap_ff);
      tok0_in.first    = !row_started_ff;
      tok0_in.last     = req_data.last;
      tok0_in.symbol   = req_data.symbol;
      tok0_in.left_old = row0_old;
      tok0_in.left_new = row0_new;
      tok0_in.remain   = qlen_ff;
      tok0_in.result   = row0_new;   // empty query: the cost is row zero
   end

   always_comb begin
      take_best   = (entry_ff == '0) || (stage_tok[MAX_QUERY_LEN].result < best_ff);
      best_in     = take_best ? stage_tok[MAX_QUERY_LEN].result : best_ff;
      best_idx_in = take_best ? entry_ff : best_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff         <= cfg_type'(2);
         mis_ff         <= cfg_type'(3);
         query_open_ff  <= 1'b0;
         qlen_ff        <= '0;
         overflow_ff    <= 1'b0;
         row_started_ff <= 1'b0;
         entry_ff       <= '0;
         best_ff        <= COST_MAX;
         best_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         tok0_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_GAP_COST:      gap_ff <= csr_wdata;
               REG_MISMATCH_COST: mis_ff <= csr_wdata;
               default:           ;
            endcase
         end

         if (enable) begin
            tok0_valid_ff <= db;
         end

         if (load) begin
            query_open_ff  <= !req_data.last;
            row_started_ff <= 1'b0;
            if (!query_open_ff) begin
               entry_ff    <= '0;
               best_ff     <= COST_MAX;
               best_idx_ff <= '0;
            end
            if (base_len < len_type'(MAX_QUERY_LEN)) begin
               qlen_ff     <= base_len + len_type'(1);
               overflow_ff <= query_open_ff ? overflow_ff : 1'b0;
            end else begin
               qlen_ff     <= base_len;
               overflow_ff <= 1'b1;
            end
         end else if (db) begin
            query_open_ff  <= 1'b0;
            row_started_ff <= !req_data.last;
         end

         if (complete) begin
            best_ff      <= best_in;
            best_idx_ff  <= best_idx_in;
            entry_ff     <= (entry_ff != ENTRY_MAX) ? entry_ff + ENTRY_W'(1) : entry_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (db) begin
         row0_ff <= row0_new;
      end
      if (enable) begin
         tok0_ff <= tok0_in;
      end
      if (complete) begin
         rsp_ff.entry_cost     <= clamp16(stage_tok[MAX_QUERY_LEN].result);
         rsp_ff.entry_index    <= entry_ff;
         rsp_ff.min_cost       <= clamp16(best_in);
         rsp_ff.best_index     <= best_idx_in;
         rsp_ff.query_overflow <= overflow_ff;
      end
   end

   generate
      for (genvar k = 0; k < MAX_QUERY_LEN; k++) begin : g_cell
         acbm_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .enable        (enable),
            .gap_cost      (gap_ff),
            .mismatch_cost (mis_ff),
            .q_we          (q_we[k]),
            .q_symbol      (req_data.symbol),
            .in_valid      (stage_valid[k]),
            .in_tok        (stage_tok[k]),
            .out_valid     (stage_valid[k+1]),
            .out_tok       (stage_tok[k+1])
         );
      end
   endgenerate

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/acbm_cell.sv
// One cell of the alignment row: holds one query symbol and one row cost.
// Depends on acbm_pkg for the token type and saturating cost helpers.
`timescale 1ns / 1ps

module acbm_cell
   import acbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  cfg_type    gap_cost,
   input  cfg_type    mismatch_cost,
   input  logic       q_we,
   input  logic [7:0] q_symbol,
   input  logic       in_valid,
   input  token_type  in_tok,
   output logic       out_valid,
   output token_type  out_tok
);

   logic [7:0] sym_ff;
   cost_type   row_ff;
   logic       valid_ff;
   token_type  tok_ff;
   token_type  tok_in;

   cost_type   old_cost;
   cost_type   diag_cost;
   cost_type   up_cost;
   cost_type   left_cost;
   cost_type   new_cost;

   always_comb begin
      old_cost  = in_tok.first ? sat_add(in_tok.left_old, gap_cost) : row_ff;
      diag_cost = sat_add(in_tok.left_old,
                          (in_tok.symbol != sym_ff) ? mismatch_cost : '0);
      up_cost   = sat_add(old_cost, gap_cost);
      left_cost = sat_add(in_tok.left_new, gap_cost);
      new_cost  = min2(min2(diag_cost, up_cost), left_cost);

      tok_in          = in_tok;
      tok_in.left_old = old_cost;
      tok_in.left_new = new_cost;
      tok_in.remain   = (in_tok.remain != '0) ? in_tok.remain - len_type'(1) : '0;
      // capture the row value once the word reaches the query end
      tok_in.result   = (in_tok.remain == len_type'(1)) ? new_cost : in_tok.result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tok_ff <= tok_in;
         if (in_valid) begin
            row_ff <= new_cost;
         end
      end
      if (q_we) begin
         sym_ff <= q_symbol;
      end
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

FILE: rtl/acbm_checker.sv
// Port-level checks on the alignment cost block, bound to the top level.
// Depends on acbm_pkg for the request and response word types.
`timescale 1ns / 1ps

module acbm_checker
   import acbm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a waiting response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // the best entry includes the one just reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.min_cost <= rsp_data.entry_cost)
      else $error("best cost above entry cost");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.best_index <= rsp_data.entry_index)
      else $error("best index beyond entry index");

   // the row drains before a query word follows a database word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_DATABASE |=>
         !(req_valid && req_ready && req_data.op == OP_QUERY) [*MAX_QUERY_LEN + 1])
      else $error("query word taken while the row was busy");

   // nothing is reported right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind alignment_cost_best_match acbm_checker u_acbm_checker (.*);
